### rtl/length_prefixed_frame_deframer_unit_defines.svh
// Assertion macros shared by the deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define LPFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in the next cycle follows from a trigger.
`define LPFD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/lpfd_pkg.sv
package lpfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 13;
  localparam int WORD_W    = 32;
  localparam int HDR_BYTES = 4;
  localparam int MAX_FRAME = 4096;
  localparam int MIN_LEN   = 4;
  localparam int RESET_MIN = 8;
  localparam int RESET_MAX = 4096;

  // result queue: deep enough for one header burst
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'b1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_BAD_LEN = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              frame_start;
    logic              frame_end;
    logic              trailer_ok;
  } result_t;

  // group of results that one item produces, handed to the queue
  typedef struct packed {
    logic                   push;
    logic [Q_CW-1:0]        n;
    result_t [Q_DEPTH-1:0]  res;
  } burst_t;

endpackage

### rtl/lpfd_in_if.sv
interface lpfd_in_if;
  import lpfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

### rtl/lpfd_out_if.sv
interface lpfd_out_if;
  import lpfd_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_start;
  logic              frame_end;
  logic              trailer_ok;

  modport source (output valid, output kind, output out_byte, output frame_start,
                  output frame_end, output trailer_ok, input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_start,
                  input frame_end, input trailer_ok, output ready);
endinterface

### rtl/length_prefixed_frame_deframer_unit.sv
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      in_byte[7:0], chunk_end
// out_ch    out  valid/ready      kind, out_byte[7:0], frame_start, frame_end, trailer_ok
// cfg_*     in   cfg_we           cfg_idx[0], cfg_wdata[12:0]
//
// One byte per cycle when the sink keeps up; an item is held in the input
// register before its results enter a 4-entry result queue.
// A valid header releases four results at once; the item waits in the input
// register until the queue has four free entries. With the sink keeping up,
// a burst can stall the next item that has a result.
// Reset is synchronous and clears all control state.
// out_ch stalls fill the queue, then hold the input register and drop in_ch.ready.
`include "length_prefixed_frame_deframer_unit_defines.svh"

module length_prefixed_frame_deframer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  lpfd_in_if.sink                         in_ch,
  lpfd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpfd_pkg::LEN_W-1:0]      cfg_wdata
);
  import lpfd_pkg::*;

  burst_t          burst;
  logic [Q_CW-1:0] q_free;

  lpfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_byte      (in_ch.in_byte),
    .in_chunk_end (in_ch.chunk_end),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .q_free       (q_free),
    .burst        (burst)
  );

  lpfd_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .burst  (burst),
    .q_free (q_free),
    .out_ch (out_ch)
  );

  `LPFD_ASSERT_ALWAYS(a_burst_fits, clk, rst_n, (!burst.push || burst.n <= q_free), "result burst overflows queue")
  `LPFD_ASSERT_ALWAYS(a_burst_size, clk, rst_n, (!burst.push || burst.n == Q_CW'(0) || burst.n == Q_CW'(1) || burst.n == Q_CW'(HDR_BYTES)), "bad result count")
  `LPFD_ASSERT_NEXT(a_push_shows, clk, rst_n, (burst.push && burst.n != '0), out_ch.valid, "pushed result not shown")
  `LPFD_ASSERT_ALWAYS(a_bad_len_empty, clk, rst_n, (!(out_ch.valid && out_ch.kind == KIND_BAD_LEN) || (out_ch.out_byte == '0 && !out_ch.frame_start && !out_ch.frame_end && !out_ch.trailer_ok)), "length error carries data")

endmodule

### rtl/lpfd_core.sv
module lpfd_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpfd_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            in_chunk_end,
  input  logic                            cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpfd_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic [lpfd_pkg::Q_CW-1:0]       q_free,
  output lpfd_pkg::burst_t                burst
);
  import lpfd_pkg::*;

  logic              item_valid_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic              item_last_r;

  logic [LEN_W-1:0]  min_len_r;
  logic [LEN_W-1:0]  max_len_r;

  logic [3*BYTE_W-1:0] hdr_shift_r, hdr_shift_nxt;
  logic [1:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic [LEN_W-1:0]    flen_r, flen_nxt;
  logic [WORD_W-1:0]   tail_r, tail_nxt;
  logic                disc_r, disc_nxt;

  logic [WORD_W-1:0]   len_w;
  logic [WORD_W-1:0]   tail_w;
  logic [LEN_W-1:0]    lo_w, hi_w;
  logic                bad_w;
  logic                commit;
  logic [Q_CW-1:0]     n_w;
  result_t [Q_DEPTH-1:0] res_w;

  always_comb begin
    len_w  = {hdr_shift_r, item_byte_r};
    tail_w = {tail_r[WORD_W-BYTE_W-1:0], item_byte_r};
    lo_w   = (min_len_r < LEN_W'(MIN_LEN)) ? LEN_W'(MIN_LEN) : min_len_r;
    hi_w   = (max_len_r > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : max_len_r;
    bad_w  = (len_w < {{(WORD_W-LEN_W){1'b0}}, lo_w}) ||
             (len_w > {{(WORD_W-LEN_W){1'b0}}, hi_w});

    hdr_shift_nxt = hdr_shift_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    remain_nxt    = remain_r;
    flen_nxt      = flen_r;
    tail_nxt      = tail_r;
    disc_nxt      = disc_r;
    n_w           = '0;
    res_w         = '0;

    if (disc_r) begin
      // drop through the end of the chunk
      if (item_last_r) begin
        disc_nxt = 1'b0;
      end
    end else if (remain_r != '0) begin
      tail_nxt              = tail_w;
      remain_nxt            = remain_r - LEN_W'(1);
      n_w                   = Q_CW'(1);
      res_w[0].kind         = KIND_DATA;
      res_w[0].data         = item_byte_r;
      res_w[0].frame_end    = (remain_r == LEN_W'(1));
      res_w[0].trailer_ok   = (remain_r == LEN_W'(1)) &&
                              (tail_w == {{(WORD_W-LEN_W){1'b0}}, flen_r});
    end else if (hdr_cnt_r != 2'd3) begin
      hdr_shift_nxt = {hdr_shift_r[2*BYTE_W-1:0], item_byte_r};
      hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
    end else begin
      hdr_cnt_nxt   = '0;
      hdr_shift_nxt = '0;
      if (bad_w) begin
        disc_nxt      = !item_last_r;
        n_w           = Q_CW'(1);
        res_w[0].kind = KIND_BAD_LEN;
      end else begin
        flen_nxt   = len_w[LEN_W-1:0];
        remain_nxt = len_w[LEN_W-1:0] - LEN_W'(HDR_BYTES);
        tail_nxt   = len_w;
        n_w        = Q_CW'(HDR_BYTES);
        for (int i = 0; i < HDR_BYTES; i++) begin
          res_w[i].kind = KIND_DATA;
          res_w[i].data = len_w[(HDR_BYTES-1-i)*BYTE_W +: BYTE_W];
        end
        res_w[0].frame_start = 1'b1;
        // a frame of header only ends on its fourth byte
        res_w[HDR_BYTES-1].frame_end  = (len_w[LEN_W-1:0] == LEN_W'(HDR_BYTES));
        res_w[HDR_BYTES-1].trailer_ok = (len_w[LEN_W-1:0] == LEN_W'(HDR_BYTES));
      end
    end
  end

  // hold the item until the queue has room for all its results
  assign commit   = item_valid_r && (n_w <= q_free);
  assign in_ready = !item_valid_r || commit;

  assign burst.push = commit;
  assign burst.n    = n_w;
  assign burst.res  = res_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_byte_r <= in_byte;
      item_last_r <= in_chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= LEN_W'(RESET_MIN);
      max_len_r <= LEN_W'(RESET_MAX);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_FRAME_LEN: min_len_r <= cfg_wdata;
        CFG_MAX_FRAME_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_shift_r <= '0;
      hdr_cnt_r   <= '0;
      remain_r    <= '0;
      flen_r      <= '0;
      tail_r      <= '0;
      disc_r      <= 1'b0;
    end else if (commit) begin
      hdr_shift_r <= hdr_shift_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      remain_r    <= remain_nxt;
      flen_r      <= flen_nxt;
      tail_r      <= tail_nxt;
      disc_r      <= disc_nxt;
    end
  end

endmodule

### rtl/lpfd_outq.sv
module lpfd_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpfd_pkg::burst_t           burst,
  output logic [lpfd_pkg::Q_CW-1:0]  q_free,
  lpfd_out_if.source                 out_ch
);
  import lpfd_pkg::*;

  result_t         q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            pop;
  logic [Q_CW-1:0] push_n;
  result_t         head;

  assign head   = q_r[rd_ptr_r];
  assign pop    = out_ch.valid && out_ch.ready;
  assign push_n = burst.push ? burst.n : '0;
  assign q_free = Q_CW'(Q_DEPTH) - cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + push_n - (pop ? Q_CW'(1) : Q_CW'(0));
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.kind        = head.kind;
  assign out_ch.out_byte    = head.data;
  assign out_ch.frame_start = head.frame_start;
  assign out_ch.frame_end   = head.frame_end;
  assign out_ch.trailer_ok  = head.trailer_ok;

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_DEPTH; k++) begin
      if (Q_CW'(k) < push_n) begin
        q_r[wr_ptr_r + Q_AW'(k)] <= burst.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[Q_AW-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
